// File: hdl/oot_pkg.sv
`default_nettype none

package oot_pkg;

  localparam int CAPACITY    = 64;
  localparam int SOURCE_BITS = 3;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic [31:0] NO_ORG = 32'd0;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0]            origin;
    logic [31:0]            org;
    logic [31:0]            parent;
    logic [31:0]            otype;
    logic [31:0]            ret;
    logic [SOURCE_BITS-1:0] src;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic wr_hit;
    logic append;
    logic shift;
    logic dec;
    logic clear;
    logic read_idx;
    logic set_ok;
    logic set_found;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       origin_zero;
    logic       full;
    logic       idx_ok;
    logic       scan_hit;
    logic       drained;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/origin_org_table.sv
// Ordered table of up to 64 origin entries held in a single-port-write,
// single-port-read memory. Each input beat is one operation (add, remove,
// lookup, clear, read entry) and produces exactly one result beat. Entries
// are visited one per cycle through the memory read port. An add or a lookup
// scans the entries in order and stops at a matching entry; a remove scans
// up to the match, then shifts the later entries down one place a cycle.
// Clear, read entry and an operation on origin 0 skip the scan, and a
// stalled output can hold a finished operation until its result is taken.
// One operation is worked on at a time; a new beat is taken while the last
// result still waits in the output register. global_org may be written
// through the configuration port while no operation is in flight.
`default_nettype none

module origin_org_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] origin_i,
  input  wire logic [31:0] org_id_i,
  input  wire logic [31:0] parent_org_i,
  input  wire logic [31:0] origin_type_i,
  input  wire logic [31:0] retention_i,
  input  wire logic [2:0]  source_i,
  input  wire logic [5:0]  entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             ok_o,
  output logic             found_o,
  output logic [2:0]       source_out_o,
  output logic             mixed_orgs_o,
  output logic [6:0]       used_count_o,
  output logic [31:0]      entry_origin_o,
  output logic [31:0]      entry_org_o,
  output logic [31:0]      entry_parent_o,
  output logic [31:0]      entry_type_o,
  output logic [31:0]      entry_retention_o
);
  import oot_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  oot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  oot_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .origin_i          (origin_i),
    .org_id_i          (org_id_i),
    .parent_org_i      (parent_org_i),
    .origin_type_i     (origin_type_i),
    .retention_i       (retention_i),
    .source_i          (source_i),
    .entry_index_i     (entry_index_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .ok_o              (ok_o),
    .found_o           (found_o),
    .source_out_o      (source_out_o),
    .mixed_orgs_o      (mixed_orgs_o),
    .used_count_o      (used_count_o),
    .entry_origin_o    (entry_origin_o),
    .entry_org_o       (entry_org_o),
    .entry_parent_o    (entry_parent_o),
    .entry_type_o      (entry_type_o),
    .entry_retention_o (entry_retention_o)
  );

  // An append is only ever issued while there is room left in the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.append |-> !sts.full)
    else $error("append issued on a full table");

  // Once a beat is taken the block is busy with it in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // The flag can only be set by an entry in the table and is cleared with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mixed_orgs_o) |-> (used_count_o != 7'd0))
    else $error("mixed-orgs flag reported with an empty table");

endmodule

`default_nettype wire

// File: hdl/oot_ctrl.sv
`default_nettype none

module oot_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire oot_pkg::sts_t sts_i,
  output oot_pkg::cmd_t      cmd_o
);
  import oot_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts_i.kind)
          KIND_ADD, KIND_REMOVE, KIND_LOOKUP: begin
            state_d = sts_i.origin_zero ? ST_DONE : ST_SCAN;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = (sts_i.kind == KIND_REMOVE) ? ST_SHIFT : ST_DONE;
        end else if (sts_i.drained) begin
          state_d = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (sts_i.drained) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_DISPATCH: begin
        if (sts_i.kind == KIND_CLEAR) cmd_o.clear = 1'b1;
        if (sts_i.kind == KIND_READ && sts_i.idx_ok) begin
          cmd_o.read_idx = 1'b1;
          cmd_o.set_ok   = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          if (sts_i.kind == KIND_ADD) begin
            cmd_o.wr_hit = 1'b1;
            cmd_o.set_ok = 1'b1;
          end
          if (sts_i.kind == KIND_LOOKUP) cmd_o.set_found = 1'b1;
        end else if (sts_i.drained && sts_i.kind == KIND_ADD && !sts_i.full) begin
          cmd_o.append = 1'b1;
          cmd_o.set_ok = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        cmd_o.dec   = sts_i.drained;
      end
      ST_DONE: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: hdl/oot_dp.sv
`default_nettype none

module oot_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [31:0]   cfg_data_i,
  input  wire logic [2:0]    kind_i,
  input  wire logic [31:0]   origin_i,
  input  wire logic [31:0]   org_id_i,
  input  wire logic [31:0]   parent_org_i,
  input  wire logic [31:0]   origin_type_i,
  input  wire logic [31:0]   retention_i,
  input  wire logic [2:0]    source_i,
  input  wire logic [5:0]    entry_index_i,
  input  wire logic          out_stall_i,
  input  wire oot_pkg::cmd_t cmd_i,
  output oot_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  output logic               ok_o,
  output logic               found_o,
  output logic [2:0]         source_out_o,
  output logic               mixed_orgs_o,
  output logic [6:0]         used_count_o,
  output logic [31:0]        entry_origin_o,
  output logic [31:0]        entry_org_o,
  output logic [31:0]        entry_parent_o,
  output logic [31:0]        entry_type_o,
  output logic [31:0]        entry_retention_o
);
  import oot_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_q;
  entry_t item_q;
  entry_t wdata;

  logic [2:0]       kind_q;
  logic [5:0]       idx_q;
  logic [31:0]      global_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] chk_q, chk_d;
  logic             chk_vld_q, chk_vld_d;
  logic             flag_q, flag_d;
  logic             ok_q, found_q;
  logic             out_valid_q;

  logic             rd_en, we;
  logic [IDX_W-1:0] raddr, waddr;
  logic             match, rel_org, rel_par, unrel, ptr_lt;
  logic             show_src, show_ent;

  assign match   = (rd_q.origin == item_q.origin);
  assign rel_org = (rd_q.org == item_q.org) && (item_q.org != NO_ORG) &&
                   (item_q.org != global_q);
  assign rel_par = (rd_q.parent == item_q.parent) && (item_q.parent != NO_ORG) &&
                   (item_q.parent != global_q);
  assign unrel   = !(rel_org || rel_par);
  assign ptr_lt  = (ptr_q < count_q);

  assign sts_o.kind        = kind_q;
  assign sts_o.origin_zero = (item_q.origin == 32'd0);
  assign sts_o.full        = (32'(count_q) == CAPACITY);
  assign sts_o.idx_ok      = (32'(idx_q) < 32'(count_q));
  assign sts_o.scan_hit    = chk_vld_q && match;
  assign sts_o.drained     = !chk_vld_q && !ptr_lt;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  // The scan and the shift both run as a two-deep pipe: an entry is read
  // in one cycle and checked, or written one place lower, in the next.
  always_comb begin
    ptr_d     = ptr_q;
    chk_d     = chk_q;
    chk_vld_d = chk_vld_q;
    count_d   = count_q;
    flag_d    = flag_q;
    rd_en     = 1'b0;
    raddr     = IDX_W'(ptr_q);
    we        = 1'b0;
    waddr     = chk_q;
    wdata     = item_q;

    if (cmd_i.load) begin
      ptr_d     = '0;
      chk_vld_d = 1'b0;
    end

    if (cmd_i.scan) begin
      if (chk_vld_q && match) begin
        ptr_d     = CNT_W'(chk_q) + CNT_W'(1);
        chk_vld_d = 1'b0;
      end else begin
        if (chk_vld_q && kind_q == KIND_ADD && unrel) flag_d = 1'b1;
        if (ptr_lt) begin
          rd_en     = 1'b1;
          chk_d     = IDX_W'(ptr_q);
          chk_vld_d = 1'b1;
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          chk_vld_d = 1'b0;
        end
      end
    end

    if (cmd_i.wr_hit) begin
      we    = 1'b1;
      waddr = chk_q;
      wdata = item_q;
    end

    if (cmd_i.append) begin
      we      = 1'b1;
      waddr   = IDX_W'(count_q);
      wdata   = item_q;
      count_d = count_q + CNT_W'(1);
    end

    if (cmd_i.shift) begin
      if (chk_vld_q) begin
        we    = 1'b1;
        waddr = chk_q;
        wdata = rd_q;
      end
      if (ptr_lt) begin
        rd_en     = 1'b1;
        chk_d     = IDX_W'(ptr_q - CNT_W'(1));
        chk_vld_d = 1'b1;
        ptr_d     = ptr_q + CNT_W'(1);
      end else begin
        chk_vld_d = 1'b0;
      end
    end

    if (cmd_i.dec) begin
      count_d = count_q - CNT_W'(1);
      if (count_q == CNT_W'(1)) flag_d = 1'b0;
    end

    if (cmd_i.clear) begin
      count_d = '0;
      flag_d  = 1'b0;
    end

    if (cmd_i.read_idx) begin
      rd_en = 1'b1;
      raddr = IDX_W'(idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_q    <= '0;
      count_q     <= '0;
      flag_q      <= 1'b0;
      ptr_q       <= '0;
      chk_vld_q   <= 1'b0;
      ok_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) global_q <= cfg_data_i;
      count_q   <= count_d;
      flag_q    <= flag_d;
      ptr_q     <= ptr_d;
      chk_vld_q <= chk_vld_d;
      if (cmd_i.load) begin
        ok_q    <= 1'b0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.set_ok) ok_q <= 1'b1;
        if (cmd_i.set_found) found_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign show_src = found_q || (ok_q && kind_q == KIND_READ);
  assign show_ent = ok_q && (kind_q == KIND_READ);

  always_ff @(posedge clk_i) begin
    chk_q <= chk_d;
    if (cmd_i.load) begin
      kind_q        <= kind_i;
      idx_q         <= entry_index_i;
      item_q.origin <= origin_i;
      item_q.org    <= org_id_i;
      item_q.parent <= parent_org_i;
      item_q.otype  <= origin_type_i;
      item_q.ret    <= retention_i;
      item_q.src    <= SOURCE_BITS'(source_i);
    end
    if (cmd_i.emit) begin
      ok_o              <= ok_q;
      found_o           <= found_q;
      source_out_o      <= show_src ? 3'(rd_q.src) : 3'd0;
      mixed_orgs_o      <= flag_q;
      used_count_o      <= 7'(count_q);
      entry_origin_o    <= show_ent ? rd_q.origin : 32'd0;
      entry_org_o       <= show_ent ? rd_q.org    : 32'd0;
      entry_parent_o    <= show_ent ? rd_q.parent : 32'd0;
      entry_type_o      <= show_ent ? rd_q.otype  : 32'd0;
      entry_retention_o <= show_ent ? rd_q.ret    : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
